@@ design/glos_pkg.sv @@
// ----------------------------------------------------------------------------
// glos_pkg
// Shared types, constants and codes for the grid line-of-sight checker.
// ----------------------------------------------------------------------------
package glos_pkg;

  // map geometry
  localparam int GRID_DIM  = 64;
  localparam int MEM_DEPTH = GRID_DIM * GRID_DIM;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // field widths
  localparam int CELL_W     = 6;
  localparam int POS_W      = 8;
  localparam int CFG_DIM_W  = 7;
  localparam int SPAN_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int STAT_W     = 2;

  // register reset values
  localparam logic [CFG_DIM_W-1:0] GRID_WIDTH_RST  = CFG_DIM_W'(64);
  localparam logic [CFG_DIM_W-1:0] GRID_HEIGHT_RST = CFG_DIM_W'(64);
  localparam logic [SPAN_W-1:0]    MAX_SPAN_RST    = SPAN_W'(15);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPAN    = 2'd2;

  // item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_CLEAR   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OUTSIDE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FAR     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_WALL    = 2'd3;

  typedef struct packed {
    logic                    mode;
    logic [CELL_W-1:0]       cell_x;
    logic [CELL_W-1:0]       cell_y;
    logic                    wall_bit;
    logic signed [POS_W-1:0] from_x;
    logic signed [POS_W-1:0] from_y;
    logic signed [POS_W-1:0] to_x;
    logic signed [POS_W-1:0] to_y;
  } in_item_t;

  typedef struct packed {
    logic              visible;
    logic [STAT_W-1:0] status;
  } out_item_t;

  typedef enum logic [1:0] {
    S_CLR,
    S_IDLE,
    S_CHECK,
    S_WALK
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic calc;
    logic step;
    logic clr_en;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic outside;
    logic far;
    logic at_end;
    logic first;
    logic wall;
    logic clr_last;
  } sts_t;

endpackage

@@ design/grid_line_of_sight_check_top.sv @@
// ----------------------------------------------------------------------------
// grid_line_of_sight_check_top
// Tile grid line-of-sight checker with a one-bit wall map.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : items with valid/ready. mode 0 sets or clears one wall cell and
//           gives no result; mode 1 asks whether the Bresenham line between
//           two tiles is free of walls (end tiles are not tested).
//   out_* : one result per query: visible flag and status code.
//   cfg_* : register writes (grid_width, grid_height, max_span), always ready;
//           write only while no item is in flight.
// Timing:
//   write items are taken back to back. A query is range-checked and then
//   walked until it fails the range checks, meets a wall or reaches the end
//   tile; the walk visits one line cell per cycle through the single wall
//   map read port. The next item is taken in the cycle after the result load.
// Reset:
//   registers return to 64 x 64 grid and span 15; the wall map is then
//   cleared one cell a cycle through all 64 x 64 cells, with in_ready low.
// Stall:
//   a result waits in the output register; the next item is still taken.
//   A second result waits in the walk until the register is free.
// ----------------------------------------------------------------------------
module grid_line_of_sight_check_top import glos_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  // sequencing and result register
  glos_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_data.mode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // wall map and line walk
  glos_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .item      (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sts       (sts)
  );

endmodule

@@ design/glos_dp.sv @@
// ----------------------------------------------------------------------------
// glos_dp
// Datapath: configuration registers, wall map memory with its clearing
// counter, range checks and the Bresenham stepping registers.
// ----------------------------------------------------------------------------
module glos_dp import glos_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  input  in_item_t              item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output sts_t                  sts
);

  logic [CFG_DIM_W-1:0] grid_width_r;
  logic [CFG_DIM_W-1:0] grid_height_r;
  logic [SPAN_W-1:0]    max_span_r;

  logic signed [POS_W-1:0] cur_x_r, cur_y_r, to_x_r, to_y_r;
  logic signed [POS_W-1:0] cur_x_nxt, cur_y_nxt;
  logic [SPAN_W-1:0]       dx_r, dy_r;
  logic                    sx_neg_r, sy_neg_r;
  logic signed [8:0]       err_r, err_nxt;
  logic                    first_r, outside_r, far_r;

  logic [ADDR_W-1:0] clr_cnt_r;
  logic              mem [MEM_DEPTH];
  logic              rd_data_r;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              wr_en, wr_data;

  logic [CFG_DIM_W-1:0] w_eff, h_eff;
  logic signed [8:0]    diff_x, diff_y;
  logic [8:0]           adx, ady;
  logic signed [9:0]    e2, dx10, dy10;
  logic                 c_x, c_y;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-2:0] x,
                                                  input logic [POS_W-2:0] y);
    return ADDR_W'(int'(y) * GRID_DIM + int'(x));
  endfunction

  function automatic logic in_grid(input logic signed [POS_W-1:0] x,
                                   input logic signed [POS_W-1:0] y,
                                   input logic [CFG_DIM_W-1:0] w,
                                   input logic [CFG_DIM_W-1:0] h);
    return !x[POS_W-1] && !y[POS_W-1] &&
           (int'(x[POS_W-2:0]) < int'(w)) && (int'(y[POS_W-2:0]) < int'(h));
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_WIDTH_RST;
      grid_height_r <= GRID_HEIGHT_RST;
      max_span_r    <= MAX_SPAN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height_r <= cfg_data;
        CFG_MAX_SPAN:    max_span_r    <= cfg_data[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective grid size, clamped to the map
  always_comb begin
    w_eff = (int'(grid_width_r) > GRID_DIM) ? CFG_DIM_W'(GRID_DIM) : grid_width_r;
    h_eff = (int'(grid_height_r) > GRID_DIM) ? CFG_DIM_W'(GRID_DIM) : grid_height_r;
  end

  // distance to the end tile
  always_comb begin
    diff_x = {to_x_r[POS_W-1], to_x_r} - {cur_x_r[POS_W-1], cur_x_r};
    diff_y = {to_y_r[POS_W-1], to_y_r} - {cur_y_r[POS_W-1], cur_y_r};
    adx    = diff_x[8] ? 9'(-diff_x) : 9'(diff_x);
    ady    = diff_y[8] ? 9'(-diff_y) : 9'(diff_y);
  end

  // one bresenham step
  always_comb begin
    e2   = {err_r, 1'b0};
    dx10 = $signed({4'b0, dx_r});
    dy10 = $signed({4'b0, dy_r});
    c_x  = e2 > -dy10;
    c_y  = e2 < dx10;
    err_nxt = err_r - (c_x ? $signed({3'b0, dy_r}) : 9'sd0)
                    + (c_y ? $signed({3'b0, dx_r}) : 9'sd0);
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    if (c_x) begin
      cur_x_nxt = cur_x_r + (sx_neg_r ? -8'sd1 : 8'sd1);
    end
    if (c_y) begin
      cur_y_nxt = cur_y_r + (sy_neg_r ? -8'sd1 : 8'sd1);
    end
  end

  // query registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_x_r <= item.from_x;
      cur_y_r <= item.from_y;
      to_x_r  <= item.to_x;
      to_y_r  <= item.to_y;
    end else if (cmd.calc) begin
      outside_r <= !in_grid(cur_x_r, cur_y_r, w_eff, h_eff) ||
                   !in_grid(to_x_r, to_y_r, w_eff, h_eff);
      far_r     <= (adx > 9'(max_span_r)) || (ady > 9'(max_span_r));
      dx_r      <= adx[SPAN_W-1:0];
      dy_r      <= ady[SPAN_W-1:0];
      sx_neg_r  <= !(diff_x > 9'sd0);
      sy_neg_r  <= !(diff_y > 9'sd0);
      err_r     <= $signed({3'b0, adx[SPAN_W-1:0]}) - $signed({3'b0, ady[SPAN_W-1:0]});
    end else if (cmd.step) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      err_r   <= err_nxt;
    end
  end

  // first point of the walk is never tested
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b0;
    end else if (cmd.calc) begin
      first_r <= 1'b1;
    end else if (cmd.step) begin
      first_r <= 1'b0;
    end
  end

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // memory port selection; a held point re-reads itself
  always_comb begin
    rd_addr = cmd.step ? cell_addr(cur_x_nxt[POS_W-2:0], cur_y_nxt[POS_W-2:0])
                       : cell_addr(cur_x_r[POS_W-2:0], cur_y_r[POS_W-2:0]);
    wr_en   = 1'b0;
    wr_addr = clr_cnt_r;
    wr_data = 1'b0;
    if (cmd.clr_en) begin
      wr_en = 1'b1;
    end else if (cmd.accept && item.mode == MODE_WRITE &&
                 int'(item.cell_x) < GRID_DIM && int'(item.cell_y) < GRID_DIM) begin
      wr_en   = 1'b1;
      wr_addr = ADDR_W'(int'(item.cell_y) * GRID_DIM + int'(item.cell_x));
      wr_data = item.wall_bit;
    end
  end

  // wall map
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  // status to the controller
  always_comb begin
    sts.outside  = outside_r;
    sts.far      = far_r;
    sts.at_end   = (cur_x_r == to_x_r) && (cur_y_r == to_y_r);
    sts.first    = first_r;
    sts.wall     = rd_data_r;
    sts.clr_last = clr_cnt_r == ADDR_W'(MEM_DEPTH - 1);
  end

  a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> !first_r)
    else $error("first flag still set after a step");

  a_clr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.clr_en && !sts.clr_last) |=> clr_cnt_r == $past(clr_cnt_r) + 1'b1)
    else $error("clearing sweep skipped an entry");

endmodule

@@ design/glos_ctrl.sv @@
// ----------------------------------------------------------------------------
// glos_ctrl
// Controller: clearing sweep, item intake, walk sequencing and the result
// output register.
// ----------------------------------------------------------------------------
module glos_ctrl import glos_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_mode,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  output cmd_t      cmd,
  input  sts_t      sts
);

  state_t            state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r;
  logic              out_free;
  logic              walk_done;
  logic [STAT_W-1:0] walk_code;
  logic              res_load;

  // walk decision, checks in priority order
  always_comb begin
    out_free  = !out_valid_r || out_ready;
    walk_done = 1'b1;
    walk_code = STAT_CLEAR;
    if (sts.outside) begin
      walk_code = STAT_OUTSIDE;
    end else if (sts.far) begin
      walk_code = STAT_FAR;
    end else if (sts.at_end) begin
      walk_code = STAT_CLEAR;
    end else if (!sts.first && sts.wall) begin
      walk_code = STAT_WALL;
    end else begin
      walk_done = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_mode == MODE_QUERY) state_nxt = S_CHECK;
      end
      S_CHECK: state_nxt = S_WALK;
      S_WALK: begin
        if (walk_done && out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    res_load   = 1'b0;
    case (state_r)
      S_CLR:   cmd.clr_en = 1'b1;
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_CHECK: cmd.calc = 1'b1;
      S_WALK: begin
        cmd.step = !walk_done;
        res_load = walk_done && out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r <= walk_code;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data.status  = out_status_r;
  assign out_data.visible = out_status_r == STAT_CLEAR;

  a_res_slot: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending transfer");

  a_calc_walk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.calc |=> (state_r == S_WALK) && sts.first)
    else $error("walk did not start after range checks");

  a_busy_no_intake: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step || cmd.calc || cmd.clr_en) |-> !in_ready)
    else $error("input taken while busy");

endmodule
